// File: design/fca_pkg.sv
// ----------------------------------------------------------------------------
// fca_pkg: shared types and constants for the fixed chunk allocator
// Field widths, result codes, register indexes and parameter defaults.
// ----------------------------------------------------------------------------
package fca_pkg;

  // Port field widths
  localparam int ADDR_W  = 20;
  localparam int CHUNK_W = 13;
  localparam int BIN_W   = 17;
  localparam int CODE_W  = 2;
  localparam int CIDX_W  = 2;

  // Parameter defaults
  localparam int FREE_DEPTH_DEF = 256;
  localparam int MAX_BINS_DEF   = 64;
  localparam int ADDR_BITS_DEF  = 20;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_CHUNK_UNITS = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_BIN_UNITS   = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_HEAP_BASE   = 2'd2;

  // Result source codes
  localparam logic [CODE_W-1:0] SRC_FREE_STORE = 2'd0;
  localparam logic [CODE_W-1:0] SRC_WILD_SPLIT = 2'd1;
  localparam logic [CODE_W-1:0] SRC_WILD_WHOLE = 2'd2;
  localparam logic [CODE_W-1:0] SRC_NEW_BIN    = 2'd3;

  // Result status codes
  localparam logic [CODE_W-1:0] ST_OK          = 2'd0;
  localparam logic [CODE_W-1:0] ST_OUT_OF_BINS = 2'd1;
  localparam logic [CODE_W-1:0] ST_STORE_FULL  = 2'd2;

  // Request modes
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture an accepted request, start the store read
    logic commit;  // update state and load the result register
  } fca_cmd_t;

endpackage

// File: design/fca_req_if.sv
// ----------------------------------------------------------------------------
// fca_req_if: request channel
// Allocate or free requests with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface fca_req_if;
  import fca_pkg::*;

  logic              valid;
  logic              ready;
  logic              mode;
  logic [ADDR_W-1:0] free_addr;

  modport src (output valid, output mode, output free_addr, input ready);
  modport snk (input valid, input mode, input free_addr, output ready);
endinterface

// File: design/fca_rsp_if.sv
// ----------------------------------------------------------------------------
// fca_rsp_if: result channel
// One result beat per request, with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface fca_rsp_if;
  import fca_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] result_addr;
  logic [CODE_W-1:0] source;
  logic [CODE_W-1:0] status;

  modport src (output valid, output result_addr, output source, output status,
               input ready);
  modport snk (input valid, input result_addr, input source, input status,
               output ready);
endinterface

// File: design/fca_cfg_if.sv
// ----------------------------------------------------------------------------
// fca_cfg_if: configuration write channel
// Register index and write data with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface fca_cfg_if;
  import fca_pkg::*;

  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] index;
  logic [ADDR_W-1:0] data;

  modport src (output valid, output index, output data, input ready);
  modport snk (input valid, input index, input data, output ready);
endinterface

// File: design/fca_ctrl.sv
// ----------------------------------------------------------------------------
// fca_ctrl: request sequencer
// Takes one request, waits for the result slot, then commits it.
// ----------------------------------------------------------------------------
module fca_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output fca_pkg::fca_cmd_t cmd
);
  import fca_pkg::*;

  typedef enum logic {
    IDLE,
    RUN
  } state_t;

  state_t state;

  always_comb begin
    cmd.load   = in_valid && in_ready;
    cmd.commit = (state == RUN) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (cmd.load) begin
            state    <= RUN;
            in_ready <= 1'b0;
          end
          if (out_ready) begin
            out_valid <= 1'b0;
          end
        end
        RUN: begin
          // hold here while the previous result is still unread
          if (cmd.commit) begin
            state     <= IDLE;
            in_ready  <= 1'b1;
            out_valid <= 1'b1;
          end
        end
        default: begin
          state    <= IDLE;
          in_ready <= 1'b1;
        end
      endcase
    end
  end

endmodule

// File: design/fca_dp.sv
// ----------------------------------------------------------------------------
// fca_dp: allocator datapath
// Configuration registers, free store memory, wilderness and bin state,
// and the result register.
// ----------------------------------------------------------------------------
module fca_dp #(
  parameter int FREE_DEPTH = fca_pkg::FREE_DEPTH_DEF,
  parameter int MAX_BINS   = fca_pkg::MAX_BINS_DEF,
  parameter int ADDR_BITS  = fca_pkg::ADDR_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  fca_pkg::fca_cmd_t             cmd,
  input  logic                          in_mode,
  input  logic [fca_pkg::ADDR_W-1:0]    in_free_addr,
  input  logic                          cfg_we,
  input  logic [fca_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [fca_pkg::ADDR_W-1:0]    cfg_data,
  output logic [fca_pkg::ADDR_W-1:0]    result_addr,
  output logic [fca_pkg::CODE_W-1:0]    source,
  output logic [fca_pkg::CODE_W-1:0]    status
);
  import fca_pkg::*;

  localparam int FIDX_W = $clog2(FREE_DEPTH);
  localparam int FCNT_W = $clog2(FREE_DEPTH + 1);
  localparam int BCNT_W = $clog2(MAX_BINS + 1);
  localparam int PROD_W = BCNT_W + BIN_W;

  typedef logic [ADDR_BITS-1:0] addr_t;

  // Configuration
  logic [CHUNK_W-1:0] chunk_units;
  logic [BIN_W-1:0]   bin_units;
  logic [ADDR_W-1:0]  heap_base;

  // Allocator state
  addr_t              free_mem [FREE_DEPTH];
  logic [FCNT_W-1:0]  free_count;
  addr_t              wild_base;
  logic [BIN_W-1:0]   wild_size;
  logic [BCNT_W-1:0]  bins_used;

  // Captured request
  logic               req_mode;
  addr_t              req_hdr;
  addr_t              pop_hdr;
  logic [PROD_W-1:0]  bin_offset;

  // Next values
  logic [FCNT_W-1:0]  free_count_next;
  addr_t              wild_base_next;
  logic [BIN_W-1:0]   wild_size_next;
  logic [BCNT_W-1:0]  bins_used_next;
  logic [ADDR_W-1:0]  result_addr_next;
  logic [CODE_W-1:0]  source_next;
  logic [CODE_W-1:0]  status_next;
  logic               push_ok;

  logic [FCNT_W-1:0]  cnt_dec;
  logic [BIN_W-1:0]   chunk_ext;
  logic [BIN_W-1:0]   split_size;
  logic [BIN_W-1:0]   bin_left;
  addr_t              hdr;
  addr_t              user_addr;
  addr_t              new_base;

  assign cnt_dec   = free_count - 1'b1;
  assign chunk_ext = BIN_W'(chunk_units);

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_units <= CHUNK_W'(4);
      bin_units   <= BIN_W'(1024);
      heap_base   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CHUNK_UNITS: chunk_units <= cfg_data[CHUNK_W-1:0];
        CFG_BIN_UNITS:   bin_units   <= cfg_data[BIN_W-1:0];
        CFG_HEAP_BASE:   heap_base   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capture the request; read the top of the store and form the bin offset
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_mode   <= in_mode;
      req_hdr    <= ADDR_BITS'(in_free_addr) - 1'b1;
      pop_hdr    <= free_mem[cnt_dec[FIDX_W-1:0]];
      bin_offset <= PROD_W'(bins_used) * PROD_W'(bin_units);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && push_ok) begin
      free_mem[free_count[FIDX_W-1:0]] <= req_hdr;
    end
  end

  always_comb begin
    free_count_next = free_count;
    wild_base_next  = wild_base;
    wild_size_next  = wild_size;
    bins_used_next  = bins_used;
    source_next     = SRC_FREE_STORE;
    status_next     = ST_OK;
    push_ok         = 1'b0;
    hdr             = '0;
    user_addr       = '0;
    split_size      = wild_size - chunk_ext;
    bin_left        = (bin_units > chunk_ext) ? (bin_units - chunk_ext) : '0;
    new_base        = ADDR_BITS'(heap_base) + ADDR_BITS'(bin_offset);

    if (req_mode == MODE_FREE) begin
      if (free_count == FCNT_W'(FREE_DEPTH)) begin
        status_next = ST_STORE_FULL;
      end else begin
        push_ok         = 1'b1;
        free_count_next = free_count + 1'b1;
      end
    end else if (free_count != '0) begin
      free_count_next = cnt_dec;
      hdr             = pop_hdr;
      user_addr       = hdr + 1'b1;
    end else if (wild_size > chunk_ext) begin
      // carve from the top of the wilderness
      wild_size_next = split_size;
      hdr            = wild_base + ADDR_BITS'(split_size);
      user_addr      = hdr + 1'b1;
      source_next    = SRC_WILD_SPLIT;
    end else if (wild_size != '0 && wild_size == chunk_ext) begin
      wild_size_next = '0;
      hdr            = wild_base;
      user_addr      = hdr + 1'b1;
      source_next    = SRC_WILD_WHOLE;
    end else if (bins_used == BCNT_W'(MAX_BINS)) begin
      source_next = SRC_NEW_BIN;
      status_next = ST_OUT_OF_BINS;
    end else begin
      wild_base_next = new_base;
      wild_size_next = bin_left;
      bins_used_next = bins_used + 1'b1;
      hdr            = new_base + ADDR_BITS'(bin_left);
      user_addr      = hdr + 1'b1;
      source_next    = SRC_NEW_BIN;
    end
    result_addr_next = ADDR_W'(user_addr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_count <= '0;
      wild_base  <= '0;
      wild_size  <= '0;
      bins_used  <= '0;
    end else if (cmd.commit) begin
      free_count <= free_count_next;
      wild_base  <= wild_base_next;
      wild_size  <= wild_size_next;
      bins_used  <= bins_used_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      result_addr <= result_addr_next;
      source      <= source_next;
      status      <= status_next;
    end
  end

endmodule

// File: design/fixed_chunk_allocator.sv
// ----------------------------------------------------------------------------
// fixed_chunk_allocator: fixed-size chunk allocator
// Serves chunks from a LIFO free store, then the wilderness, then new bins.
//
//   port  role  payload                        handshake
//   req   sink  mode, free_addr                valid / ready
//   rsp   src   result_addr, source, status    valid / ready
//   cfg   sink  index, data                    valid / ready (ready held high)
//
// A request is committed in the RUN state after it is accepted: the registered read
// of the free store and the registered bin offset product lie between the two, and
// the block takes no new request until the last one is committed.
// A new request is taken while a result waits; its commit then holds until
// the result register is free. Reset is synchronous; the free store needs no
// clearing, as only entries below the fill count are read.
// ----------------------------------------------------------------------------
module fixed_chunk_allocator #(
  parameter int FREE_DEPTH = fca_pkg::FREE_DEPTH_DEF,
  parameter int MAX_BINS   = fca_pkg::MAX_BINS_DEF,
  parameter int ADDR_BITS  = fca_pkg::ADDR_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  fca_req_if.snk    req,
  fca_rsp_if.src    rsp,
  fca_cfg_if.snk    cfg
);
  import fca_pkg::*;

  fca_cmd_t cmd;

  assign cfg.ready = 1'b1;

  fca_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  fca_dp #(
    .FREE_DEPTH (FREE_DEPTH),
    .MAX_BINS   (MAX_BINS),
    .ADDR_BITS  (ADDR_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .in_mode      (req.mode),
    .in_free_addr (req.free_addr),
    .cfg_we       (cfg.valid),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .result_addr  (rsp.result_addr),
    .source       (rsp.source),
    .status       (rsp.status)
  );

endmodule

// File: dv/fixed_chunk_allocator_tb.sv
// ----------------------------------------------------------------------------
// fixed_chunk_allocator_tb: self-checking bench for the fixed chunk allocator
// Runs a short table of directed requests, then several random phases with
// different chunk, bin and heap settings. Every result beat is compared against
// a table entry or an in-bench model of the free store, wilderness and bin counter.
// Requests arrive in bursts; the result side stalls on its own pattern and
// now and then holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module fixed_chunk_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fca_pkg::*;

  localparam int FREE_DEPTH   = FREE_DEPTH_DEF;
  localparam int MAX_BINS     = MAX_BINS_DEF;
  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_PRINTS   = 40;
  localparam int LIMIT_NS     = 4_000_000;

  // index with no register behind it; writes to it must be dropped
  localparam logic [CIDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [CODE_W-1:0] source;
    logic [CODE_W-1:0] status;
  } grant_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [CIDX_W-1:0] sel;
    logic              mode;
    logic [ADDR_W-1:0] value;
    logic              known;
    grant_t            want;
  } dir_row_t;

  typedef struct {
    logic [ADDR_W-1:0] chunk_data;
    logic [ADDR_W-1:0] bin_data;
    logic [ADDR_W-1:0] base_data;
    int                items;
    int                free_pct;
    bit                hold;
  } phase_t;

  logic clk = 1'b0;
  logic rst;

  fca_req_if req ();
  fca_rsp_if rsp ();
  fca_cfg_if cfg ();

  fixed_chunk_allocator DUT (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Allocator model state
  logic [CHUNK_W-1:0] cur_chunk = 13'd4;
  logic [BIN_W-1:0]   cur_bin   = 17'd1024;
  logic [ADDR_W-1:0]  cur_base  = '0;
  logic [ADDR_W-1:0]  free_hdrs [FREE_DEPTH];
  int                 store_fill  = 0;
  logic [ADDR_W-1:0]  wild_base   = '0;
  logic [BIN_W-1:0]   wild_sz     = '0;
  int                 bins_opened = 0;

  grant_t            pending_grants [$];
  logic [ADDR_W-1:0] live_chunks [$];

  int  mismatches;
  int  requests_taken;
  int  frees_taken;
  int  store_full_hits;
  int  out_of_bins_hits;
  int  alloc_from [4];
  bit  hold_arm;

  function automatic grant_t serve_request(logic m, logic [ADDR_W-1:0] a);
    grant_t      g;
    int unsigned off;
    logic [BIN_W-1:0] chunk_w;
    g = '{addr: '0, source: SRC_FREE_STORE, status: ST_OK};
    chunk_w = BIN_W'(cur_chunk);
    if (m == MODE_FREE) begin
      if (store_fill >= FREE_DEPTH) begin
        g.status = ST_STORE_FULL;
      end else begin
        free_hdrs[store_fill] = a - 1'b1;
        store_fill++;
      end
      return g;
    end
    if (store_fill > 0) begin
      store_fill--;
      g.addr = free_hdrs[store_fill] + 1'b1;
    end else if (wild_sz > chunk_w) begin
      wild_sz  = wild_sz - chunk_w;
      g.addr   = wild_base + ADDR_W'(wild_sz) + 1'b1;
      g.source = SRC_WILD_SPLIT;
    end else if (wild_sz != '0 && wild_sz == chunk_w) begin
      // an empty wilderness never counts as a whole chunk
      g.addr   = wild_base + 1'b1;
      wild_sz  = '0;
      g.source = SRC_WILD_WHOLE;
    end else if (bins_opened >= MAX_BINS) begin
      g.source = SRC_NEW_BIN;
      g.status = ST_OUT_OF_BINS;
    end else begin
      off         = unsigned'(bins_opened) * 32'(cur_bin);
      wild_base   = cur_base + off[ADDR_W-1:0];
      bins_opened++;
      wild_sz     = (cur_bin > chunk_w) ? cur_bin - chunk_w : '0;
      g.addr      = wild_base + ADDR_W'(wild_sz) + 1'b1;
      g.source    = SRC_NEW_BIN;
    end
    return g;
  endfunction

  function automatic dir_row_t ask(logic m, logic [ADDR_W-1:0] a);
    return '{kind: ROW_REQ, sel: CFG_CHUNK_UNITS, mode: m, value: a, known: 1'b0,
             want: '0};
  endfunction

  function automatic dir_row_t ask_known(logic m, logic [ADDR_W-1:0] a,
                                         logic [ADDR_W-1:0] ea,
                                         logic [CODE_W-1:0] es,
                                         logic [CODE_W-1:0] est);
    dir_row_t r;
    r       = ask(m, a);
    r.known = 1'b1;
    r.want  = '{addr: ea, source: es, status: est};
    return r;
  endfunction

  function automatic dir_row_t write_reg(logic [CIDX_W-1:0] sel, logic [ADDR_W-1:0] v);
    return '{kind: ROW_CFG, sel: sel, mode: MODE_ALLOC, value: v, known: 1'b0,
             want: '0};
  endfunction

  task automatic report_mismatch(string what, logic [ADDR_W-1:0] got,
                                 logic [ADDR_W-1:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("%0t mismatch on %s: got %h, want %h", $time, what, got, want);
  endtask

  task automatic send_req(logic m, logic [ADDR_W-1:0] a, logic known, grant_t want);
    grant_t g;
    @(negedge clk);
    req.valid     <= 1'b1;
    req.mode      <= m;
    req.free_addr <= a;
    do @(posedge clk); while (!req.ready);
    g = serve_request(m, a);
    pending_grants.push_back(known ? want : g);
    requests_taken++;
    if (m == MODE_FREE) begin
      if (g.status == ST_STORE_FULL) store_full_hits++;
      else frees_taken++;
    end else if (g.status == ST_OUT_OF_BINS) begin
      out_of_bins_hits++;
    end else begin
      alloc_from[g.source]++;
      live_chunks.push_back(g.addr);
    end
  endtask

  task automatic pause_req(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      req.valid <= 1'b0;
    end
  endtask

  // drop the request valid and wait for every outstanding result beat
  task automatic settle();
    pause_req(1);
    while (pending_grants.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CIDX_W-1:0] sel, logic [ADDR_W-1:0] value);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= sel;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
    case (sel)
      CFG_CHUNK_UNITS: cur_chunk = value[CHUNK_W-1:0];
      CFG_BIN_UNITS:   cur_bin   = value[BIN_W-1:0];
      CFG_HEAP_BASE:   cur_base  = value;
      default: ;
    endcase
  endtask

  initial begin : stimulus
    dir_row_t          plan [$];
    phase_t            phases [7];
    bit                cfg_open;
    int                sent;
    int                burst;
    int                gap;
    int                pick;
    logic              m;
    logic [ADDR_W-1:0] a;

    rst           = 1'b1;
    req.valid     = 1'b0;
    req.mode      = MODE_ALLOC;
    req.free_addr = '0;
    cfg.valid     = 1'b0;
    cfg.index     = CFG_CHUNK_UNITS;
    cfg.data      = '0;
    cfg_open      = 1'b0;

    plan = '{
      ask_known(MODE_ALLOC, 20'd0, 20'd1021, SRC_NEW_BIN, ST_OK),
      ask_known(MODE_ALLOC, 20'd0, 20'd1017, SRC_WILD_SPLIT, ST_OK),
      ask_known(MODE_FREE, 20'd1021, 20'd0, SRC_FREE_STORE, ST_OK),
      ask_known(MODE_FREE, 20'h00000, 20'd0, SRC_FREE_STORE, ST_OK),
      ask_known(MODE_FREE, 20'hFFFFF, 20'd0, SRC_FREE_STORE, ST_OK),
      ask_known(MODE_ALLOC, 20'd0, 20'hFFFFF, SRC_FREE_STORE, ST_OK),
      ask_known(MODE_ALLOC, 20'd0, 20'h00000, SRC_FREE_STORE, ST_OK),
      ask_known(MODE_ALLOC, 20'd0, 20'd1021, SRC_FREE_STORE, ST_OK),
      ask(MODE_ALLOC, 20'hFFFFF),
      // chunk equal to what is left of the wilderness takes it whole
      write_reg(CFG_CHUNK_UNITS, 20'd1012),
      ask_known(MODE_ALLOC, 20'd0, 20'd1, SRC_WILD_WHOLE, ST_OK),
      write_reg(CFG_CHUNK_UNITS, 20'd8),
      write_reg(CFG_BIN_UNITS, 20'd16),
      write_reg(CFG_HEAP_BASE, 20'hFFFFF),
      ask(MODE_ALLOC, 20'd0),
      ask(MODE_ALLOC, 20'd0),
      // chunk larger than a bin leaves no wilderness behind
      write_reg(CFG_CHUNK_UNITS, 20'd4096),
      ask(MODE_ALLOC, 20'd0),
      ask(MODE_ALLOC, 20'd0),
      write_reg(CFG_CHUNK_UNITS, 20'd0),
      ask(MODE_ALLOC, 20'd0),
      ask(MODE_ALLOC, 20'd0),
      write_reg(CFG_CHUNK_UNITS, 20'd2),
      write_reg(CFG_SPARE, 20'hFFFFF),
      ask(MODE_ALLOC, 20'd0),
      ask(MODE_FREE, 20'h80000),
      ask(MODE_ALLOC, 20'd0),
      ask(MODE_FREE, 20'd1),
      ask(MODE_ALLOC, 20'd0)
    };

    phases = '{
      '{20'd2,    20'h10000, 20'hF0000, 250, 40, 1'b1},
      '{20'd4096, 20'h10000, 20'h00000, 250, 50, 1'b0},
      '{20'd16,   20'd16,    20'hABCDE, 200, 60, 1'b0},
      '{20'd4,    20'd1024,  20'h00000, 400, 85, 1'b1},
      '{20'd3,    20'd100,   20'h12345, 350, 20, 1'b0},
      // upper bits beyond each register's width must be masked off
      '{20'hFE005, 20'hE0040, 20'h7FFFF, 200, 30, 1'b0},
      '{20'd4096, 20'd16,    20'hFFFFF, 300, 25, 1'b1}
    };

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        if (!cfg_open) settle();
        cfg_write(plan[i].sel, plan[i].value);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) begin
          @(negedge clk);
          cfg.valid <= 1'b0;
          cfg_open = 1'b0;
        end
        send_req(plan[i].mode, plan[i].value, plan[i].known, plan[i].want);
      end
    end

    foreach (phases[p]) begin
      settle();
      hold_arm = phases[p].hold;
      cfg_write(CFG_CHUNK_UNITS, phases[p].chunk_data);
      cfg_write(CFG_BIN_UNITS, phases[p].bin_data);
      cfg_write(CFG_HEAP_BASE, phases[p].base_data);
      @(negedge clk);
      cfg.valid <= 1'b0;

      sent = 0;
      while (sent < phases[p].items) begin
        burst = $urandom_range(1, 16);
        for (int k = 0; k < burst && sent < phases[p].items; k++) begin
          a = ADDR_W'($urandom);
          if ($urandom_range(0, 99) < phases[p].free_pct) begin
            m = MODE_FREE;
            // mostly hand back live chunks; the rest is stray addresses
            if (live_chunks.size() != 0 && $urandom_range(0, 3) != 0) begin
              pick = $urandom_range(0, live_chunks.size() - 1);
              a    = live_chunks[pick];
              live_chunks.delete(pick);
            end else if ($urandom_range(0, 7) == 0) begin
              a = $urandom_range(0, 1) ? '1 : '0;
            end
          end else begin
            m = MODE_ALLOC;
          end
          send_req(m, a, 1'b0, '0);
          sent++;
        end
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) pause_req(gap);
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests over 7 random settings: %0d frees,",
             requests_taken, frees_taken);
    $display("  %0d dropped on a full store, %0d refused for lack of bins",
             store_full_hits, out_of_bins_hits);
    $display("Chunks handed out: %0d from the free store, %0d split,",
             alloc_from[SRC_FREE_STORE], alloc_from[SRC_WILD_SPLIT]);
    $display("  %0d whole wilderness, %0d from new bins",
             alloc_from[SRC_WILD_WHOLE], alloc_from[SRC_NEW_BIN]);
    if (mismatches == 0) begin
      $display("PASS fixed_chunk_allocator");
    end else begin
      $display("FAIL fixed_chunk_allocator");
    end
    $finish;
  end

  initial begin : result_sink
    bit [15:0] stall_word;
    int        slot;
    int        hold_left;
    rsp.ready  = 1'b0;
    stall_word = '1;
    slot       = 0;
    hold_left  = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else if (hold_arm) begin
        // long hold-off: the block fills and must push back on requests
        hold_arm  = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        rsp.ready <= 1'b0;
      end else begin
        if (slot == 0) begin
          case ($urandom_range(0, 3))
            0:       stall_word = '1;
            1:       stall_word = 16'($urandom);
            2:       stall_word = 16'($urandom | $urandom);
            default: stall_word = 16'($urandom & $urandom);
          endcase
        end
        rsp.ready <= stall_word[slot];
        slot = (slot + 1) % 16;
      end
    end
  end

  always @(posedge clk) begin : result_check
    grant_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_grants.size() == 0) begin
        report_mismatch("result beat with nothing pending", rsp.result_addr, '0);
      end else begin
        want = pending_grants.pop_front();
        if (rsp.result_addr !== want.addr)
          report_mismatch("result_addr", rsp.result_addr, want.addr);
        if (rsp.source !== want.source)
          report_mismatch("source", 20'(rsp.source), 20'(want.source));
        if (rsp.status !== want.status)
          report_mismatch("status", 20'(rsp.status), 20'(want.status));
      end
    end
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("FAIL fixed_chunk_allocator");
    $finish;
  end

endmodule
